[rtl/rae_pkg.sv]
// Package for the register ALU executor: opcode and status codes,
// payload widths and the packed stream layouts.
// No dependencies.
package rae_pkg;

    localparam int OpcodeW  = 8;
    localparam int RegIdxW  = 3;
    localparam int DataW    = 32;
    localparam int StatusW  = 2;

    localparam int InTdataW  = 48;  // 46 payload bits, padded to whole bytes
    localparam int OutTdataW = 72;  // 68 payload bits, padded to whole bytes

    localparam logic [OpcodeW-1:0] OPC_NOP  = 8'h00;
    localparam logic [OpcodeW-1:0] OPC_MOV  = 8'h01;
    localparam logic [OpcodeW-1:0] OPC_ADD  = 8'h02;
    localparam logic [OpcodeW-1:0] OPC_SUB  = 8'h03;
    localparam logic [OpcodeW-1:0] OPC_MUL  = 8'h04;
    localparam logic [OpcodeW-1:0] OPC_CMP  = 8'h07;
    localparam logic [OpcodeW-1:0] OPC_HALT = 8'hFF;

    typedef enum logic [StatusW-1:0] {
        ST_DONE    = 2'd0,
        ST_HALTED  = 2'd1,
        ST_INVALID = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    typedef struct packed {
        logic [DataW-1:0]   immediate;
        logic [RegIdxW-1:0] source_reg;
        logic [RegIdxW-1:0] target_reg;
        logic [OpcodeW-1:0] opcode;
    } instr_t;

    typedef struct packed {
        status_t          status;
        logic             greater_flag;
        logic             equal_flag;
        logic [DataW-1:0] last_result;
        logic [DataW-1:0] target_value;
    } result_t;

endpackage

[rtl/rae_ram.sv]
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module rae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [AddrW-1:0]         waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [AddrW-1:0]         raddr_a,
    input  logic [AddrW-1:0]         raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem_reg[raddr_a];
            rdata_b <= mem_reg[raddr_b];
        end
    end

endmodule

[rtl/register_alu_executor.sv]
// Register ALU executor top level: register file in RAM with valid bits,
// one ALU stage between the operand register and the result register.
// Depends on rae_pkg and rae_ram.
//
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tdata: opcode, target_reg, source_reg, immediate
// m_       out  m_tvalid/m_tready  m_tdata: target_value, last_result, flags, status
//
// One item per cycle sustained unless m_ stalls; m_tvalid comes from the result register.
// The register file is read at the accept edge and written when the item
// moves into the result register; the last write is forwarded to the operands.
// Reset clears valid bits, flags and the stopped state at once; no clearing pass.
// A stall on m_ holds the result register and backs up into s_tready.
module register_alu_executor
    import rae_pkg::*;
#(
    parameter int NUM_REGS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [7:0] opcode, [10:8] target_reg, [13:11] source_reg, [45:14] immediate
    input  logic [InTdataW-1:0]  s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] target_value, [63:32] last_result, [64] equal_flag,
    // [65] greater_flag, [67:66] status
    output logic [OutTdataW-1:0] m_tdata
);
    localparam int AddrW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    instr_t           s_instr;
    logic             s_accept;
    logic [4:0]       s_tgt_ext;
    logic [4:0]       s_src_ext;
    logic [AddrW-1:0] s_tgt_addr;
    logic [AddrW-1:0] s_src_addr;

    // operand stage
    logic             in_valid_reg;
    instr_t           in_instr_reg;
    logic             a_valid_reg;
    logic             b_valid_reg;

    // machine state
    logic [NUM_REGS-1:0] reg_valid_reg;
    logic [NUM_REGS-1:0] reg_valid_next;
    logic [DataW-1:0]    last_result_reg;
    logic [DataW-1:0]    last_result_next;
    logic                equal_reg;
    logic                equal_next;
    logic                greater_reg;
    logic                greater_next;
    logic                stopped_reg;
    logic                stopped_next;

    // forwarding of the most recent register write
    logic                fwd_en_reg;
    logic [RegIdxW-1:0]  fwd_idx_reg;
    logic [DataW-1:0]    fwd_data_reg;

    // result stage
    logic                out_valid_reg;
    result_t             out_reg;
    result_t             out_next;

    logic             exec;
    logic [DataW-1:0] ram_a;
    logic [DataW-1:0] ram_b;
    logic [DataW-1:0] op_a;
    logic [DataW-1:0] op_b;
    logic             t_in_range;
    logic             s_in_range;
    logic             wr_en;
    logic [DataW-1:0] wr_data;
    logic [4:0]       t_ext;
    logic [AddrW-1:0] t_addr;
    status_t          status;

    assign s_instr  = instr_t'(s_tdata[$bits(instr_t)-1:0]);
    assign exec     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || exec;
    assign s_accept = s_tvalid && s_tready;

    assign s_tgt_ext  = 5'(s_instr.target_reg);
    assign s_src_ext  = 5'(s_instr.source_reg);
    assign s_tgt_addr = s_tgt_ext[AddrW-1:0];
    assign s_src_addr = s_src_ext[AddrW-1:0];

    assign t_ext  = 5'(in_instr_reg.target_reg);
    assign t_addr = t_ext[AddrW-1:0];

    rae_ram #(
        .WIDTH (DataW),
        .DEPTH (NUM_REGS)
    ) u_regfile (
        .aclk    (aclk),
        .we      (wr_en),
        .waddr   (t_addr),
        .wdata   (wr_data),
        .re      (s_accept),
        .raddr_a (s_tgt_addr),
        .raddr_b (s_src_addr),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    // Operand: zero if out of range, else last write, stored entry if ever written, or zero.
    always_comb begin
        t_in_range = 32'(in_instr_reg.target_reg) < NUM_REGS;
        s_in_range = 32'(in_instr_reg.source_reg) < NUM_REGS;
        if (!t_in_range) begin
            op_a = '0;
        end else if (fwd_en_reg && fwd_idx_reg == in_instr_reg.target_reg) begin
            op_a = fwd_data_reg;
        end else if (a_valid_reg) begin
            op_a = ram_a;
        end else begin
            op_a = '0;
        end
        if (!s_in_range) begin
            op_b = '0;
        end else if (fwd_en_reg && fwd_idx_reg == in_instr_reg.source_reg) begin
            op_b = fwd_data_reg;
        end else if (b_valid_reg) begin
            op_b = ram_b;
        end else begin
            op_b = '0;
        end
    end

    always_comb begin
        last_result_next = last_result_reg;
        equal_next       = equal_reg;
        greater_next     = greater_reg;
        stopped_next     = stopped_reg;
        status           = ST_DONE;
        wr_data          = in_instr_reg.immediate;
        wr_en            = 1'b0;
        if (stopped_reg) begin
            status = ST_IGNORED;
        end else begin
            unique case (in_instr_reg.opcode)
                OPC_NOP: begin
                end
                OPC_MOV: begin
                    wr_en = 1'b1;
                end
                OPC_ADD: begin
                    last_result_next = op_a + op_b;
                    wr_data          = last_result_next;
                    wr_en            = 1'b1;
                end
                OPC_SUB: begin
                    last_result_next = op_a - op_b;
                    wr_data          = last_result_next;
                    wr_en            = 1'b1;
                end
                OPC_MUL: begin
                    last_result_next = op_a * op_b;
                    wr_data          = last_result_next;
                    wr_en            = 1'b1;
                end
                OPC_CMP: begin
                    equal_next   = op_a == op_b;
                    greater_next = op_a > op_b;
                end
                OPC_HALT: begin
                    stopped_next = 1'b1;
                    status       = ST_HALTED;
                end
                default: begin
                    stopped_next = 1'b1;
                    status       = ST_INVALID;
                end
            endcase
        end
        // drop writes to registers that do not exist
        wr_en = wr_en && exec && t_in_range;

        reg_valid_next = reg_valid_reg;
        if (wr_en) begin
            reg_valid_next[t_addr] = 1'b1;
        end

        out_next.target_value = wr_en ? wr_data : op_a;
        out_next.last_result  = last_result_next;
        out_next.equal_flag   = equal_next;
        out_next.greater_flag = greater_next;
        out_next.status       = status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            reg_valid_reg   <= '0;
            last_result_reg <= '0;
            equal_reg       <= 1'b0;
            greater_reg     <= 1'b0;
            stopped_reg     <= 1'b0;
            fwd_en_reg      <= 1'b0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (exec) begin
                in_valid_reg <= 1'b0;
            end
            if (exec) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (exec) begin
                reg_valid_reg   <= reg_valid_next;
                last_result_reg <= last_result_next;
                equal_reg       <= equal_next;
                greater_reg     <= greater_next;
                stopped_reg     <= stopped_next;
            end
            if (wr_en) begin
                fwd_en_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_instr_reg <= s_instr;
            a_valid_reg  <= reg_valid_reg[s_tgt_addr];
            b_valid_reg  <= reg_valid_reg[s_src_addr];
        end
        if (wr_en) begin
            fwd_idx_reg  <= in_instr_reg.target_reg;
            fwd_data_reg <= wr_data;
        end
        if (exec) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OutTdataW'(out_reg);

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_halt_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        exec && !stopped_reg && in_instr_reg.opcode == OPC_HALT |=> stopped_reg)
        else $error("halt did not stop the block");

    a_no_write_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |-> !wr_en)
        else $error("register write while stopped");

    a_ignored_status: assert property (@(posedge aclk) disable iff (!aresetn)
        exec && stopped_reg |=> m_tvalid && out_reg.status == ST_IGNORED)
        else $error("item after stop not reported as ignored");

    a_stopped_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |=> stopped_reg)
        else $error("stopped state cleared without reset");

endmodule
